// File: hw/rtl/mqttpp_pkg.sv
// Shared types, protocol codes and result field layout for the MQTT payload parser.
package mqttpp_pkg;

  // Parser position inside one control packet
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_TOPIC
  } phase_t;

  // Control packet types that the parser inspects
  localparam logic [3:0] T_CONNECT    = 4'd1;
  localparam logic [3:0] T_CONNACK    = 4'd2;
  localparam logic [3:0] T_PUBLISH    = 4'd3;
  localparam logic [3:0] T_DISCONNECT = 4'd14;

  // Byte values checked in the remaining length and the body
  localparam logic [7:0] LEN_CONT_BIT  = 8'h80;
  localparam logic [7:0] HASH_CHAR     = 8'h23;
  localparam logic [7:0] NAME_LEN_LO   = 8'h04;
  localparam logic [7:0] VERSION_311   = 8'h04;
  localparam logic [7:0] VERSION_500   = 8'h05;
  localparam logic [7:0] PROTO_NAME [4] = '{8'h4D, 8'h51, 8'h54, 8'h54};

  // CONNECT body offsets
  localparam logic [3:0] OFS_NAME_HI   = 4'd0;
  localparam logic [3:0] OFS_NAME_LO   = 4'd1;
  localparam logic [3:0] OFS_NAME_LAST = 4'd5;
  localparam logic [3:0] OFS_VERSION   = 4'd6;
  localparam logic [3:0] OFS_FLAGS     = 4'd7;
  localparam logic [3:0] OFS_KA_HI     = 4'd8;
  localparam logic [3:0] OFS_KA_LO     = 4'd9;
  localparam logic [3:0] OFS_MAX       = 4'd15;

  // Result transaction layout on the master tdata bus
  localparam int OUT_W          = 72;
  localparam int VALID_LSB      = 0;
  localparam int TMASK_LSB      = 1;
  localparam int VERSION_LSB    = 17;
  localparam int CFLAGS_LSB     = 25;
  localparam int KALIVE_LSB     = 33;
  localparam int SESSION_LSB    = 49;
  localparam int RCODE_LSB      = 50;
  localparam int PFLAGS_LSB     = 58;
  localparam int TCOUNT_LSB     = 62;
  localparam int FLUSH_LSB      = 70;
  localparam int PAD_LSB        = 71;

endpackage

// File: hw/rtl/mqtt_payload_parser_top.sv
// Top level of the MQTT payload parser: byte-wise packet walker and per-flow record.
//
// Usage:
//   Slave channel carries one TCP payload byte per transaction in s_axis_tdata,
//   s_axis_tlast marks the last byte of a payload and s_axis_tuser marks the
//   first byte of a new flow (flow record and parse state clear before it).
//   Master channel carries one result transaction per payload, issued for the
//   byte that had s_axis_tlast set: validity, the flow record and a flush flag.
//   Throughput is one byte per cycle while s_axis_tready is high; each byte is
//   parsed by a single step of combinational logic between the parse state
//   and result registers, so the result appears in the cycle after its last byte.
//   The result register is the only stage on the output side: s_axis_tready
//   stays high while it is empty or being drained, and drops only while a
//   result is held against a low m_axis_tready.
//   Reset clears the parse state, the flow record and m_axis_tvalid; m_axis_tdata is not reset.
//   After each result the parse state clears; the flow record persists
//   until a byte with s_axis_tuser set arrives.
module mqtt_payload_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,  // end_of_payload
  input  logic                           s_axis_tuser,  // new_flow
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] payload_valid, [16:1] type_seen_mask, [24:17] protocol_version,
  // [32:25] connect_flags, [48:33] ka_seconds, [49] session_present,
  // [57:50] return_code, [61:58] pub_flags_or, [69:62] topic_count,
  // [70] flush_request, [71] zero
  output logic [mqttpp_pkg::OUT_W-1:0]  m_axis_tdata
);
  import mqttpp_pkg::*;

  // Parse state
  phase_t      phase, phase_next;
  logic [3:0]  pkt_type, pkt_type_next;
  logic [27:0] length_acc, length_acc_next;
  logic [2:0]  len_idx, len_idx_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [3:0]  hdr_off, hdr_off_next;
  logic [15:0] topic_len, topic_len_next;
  logic        failed, failed_next;
  logic        flush_seen, flush_seen_next;

  // Flow record
  logic [15:0] type_mask, type_mask_next;
  logic [7:0]  version, version_next;
  logic [7:0]  conn_flags, conn_flags_next;
  logic [15:0] ka_seconds, ka_seconds_next;
  logic        session, session_next;
  logic [7:0]  ret_code, ret_code_next;
  logic [3:0]  pub_flags, pub_flags_next;
  logic [7:0]  topic_cnt, topic_cnt_next;

  logic             in_fire;
  logic [OUT_W-1:0] result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Parse one accepted byte and build the result for a payload end
  always_comb begin
    logic       do_end;
    logic       stop;
    logic [7:0] b;
    logic [3:0] o;
    phase_t     ph;
    logic [4:0] shamt;

    phase_next      = phase;
    pkt_type_next   = pkt_type;
    length_acc_next = length_acc;
    len_idx_next    = len_idx;
    bytes_left_next = bytes_left;
    hdr_off_next    = hdr_off;
    topic_len_next  = topic_len;
    failed_next     = failed;
    flush_seen_next = flush_seen;
    type_mask_next  = type_mask;
    version_next    = version;
    conn_flags_next = conn_flags;
    ka_seconds_next = ka_seconds;
    session_next    = session;
    ret_code_next   = ret_code;
    pub_flags_next  = pub_flags;
    topic_cnt_next  = topic_cnt;
    result          = '0;
    do_end          = 1'b0;
    stop            = 1'b0;
    b               = s_axis_tdata;
    o               = '0;
    ph              = PH_HEADER;
    shamt           = '0;

    if (in_fire) begin
      // Drop the flow record and the parse state on a new flow
      if (s_axis_tuser) begin
        phase_next      = PH_HEADER;
        pkt_type_next   = '0;
        length_acc_next = '0;
        len_idx_next    = '0;
        bytes_left_next = '0;
        hdr_off_next    = '0;
        topic_len_next  = '0;
        failed_next     = 1'b0;
        flush_seen_next = 1'b0;
        type_mask_next  = '0;
        version_next    = '0;
        conn_flags_next = '0;
        ka_seconds_next = '0;
        session_next    = 1'b0;
        ret_code_next   = '0;
        pub_flags_next  = '0;
        topic_cnt_next  = '0;
      end

      ph = phase_next;
      o  = hdr_off_next;

      if (!failed_next) begin
        unique case (ph)
          // Fixed header byte: type and flags
          PH_HEADER: begin
            pkt_type_next  = b[7:4];
            type_mask_next = type_mask_next | (16'd1 << b[7:4]);
            if (b[7:4] == T_PUBLISH) pub_flags_next = pub_flags_next | b[3:0];
            length_acc_next = '0;
            len_idx_next    = '0;
            hdr_off_next    = '0;
            topic_len_next  = '0;
            phase_next      = PH_LENGTH;
          end

          // Remaining length, seven bits per byte, low group first
          PH_LENGTH: begin
            shamt = 5'(len_idx_next[1:0]) * 5'd7;
            length_acc_next = length_acc_next | ({21'd0, b[6:0]} << shamt);
            len_idx_next    = len_idx_next + 3'd1;
            if ((b & LEN_CONT_BIT) != 8'd0) begin
              if (len_idx_next >= 3'd4) failed_next = 1'b1;
            end else begin
              bytes_left_next = length_acc_next;
              phase_next      = PH_BODY;
              if (length_acc_next == 28'd0) do_end = 1'b1;
            end
          end

          // Topic characters of a PUBLISH
          PH_TOPIC: begin
            if (b == HASH_CHAR) begin
              failed_next = 1'b1;
              stop        = 1'b1;
            end else begin
              topic_len_next = topic_len_next - 16'd1;
              if (topic_len_next == 16'd0) begin
                if (topic_cnt_next != 8'hFF) topic_cnt_next = topic_cnt_next + 8'd1;
                phase_next = PH_BODY;
              end
            end
            if (!stop) begin
              bytes_left_next = bytes_left_next - 28'd1;
              if (bytes_left_next == 28'd0) do_end = 1'b1;
            end
          end

          // Other body bytes, by packet type and offset
          PH_BODY: begin
            if (pkt_type_next == T_CONNECT) begin
              if ((o == OFS_NAME_HI && b != 8'd0) ||
                  (o == OFS_NAME_LO && b != NAME_LEN_LO) ||
                  (o > OFS_NAME_LO && o <= OFS_NAME_LAST &&
                   b != PROTO_NAME[2'(o - 4'd2)])) begin
                failed_next = 1'b1;
                stop        = 1'b1;
              end else if (o == OFS_VERSION) begin
                version_next = b;
                if (b != VERSION_311 && b != VERSION_500) begin
                  failed_next = 1'b1;
                  stop        = 1'b1;
                end
              end else if (o == OFS_FLAGS) begin
                conn_flags_next = b;
              end else if (o == OFS_KA_HI) begin
                topic_len_next = {8'd0, b};
              end else if (o == OFS_KA_LO) begin
                ka_seconds_next = {topic_len_next[7:0], b};
              end
            end else if (pkt_type_next == T_CONNACK) begin
              if (o == 4'd0) session_next = b[0];
              else if (o == 4'd1) ret_code_next = b;
            end else if (pkt_type_next == T_PUBLISH) begin
              if (o == 4'd0) begin
                topic_len_next = {b, 8'd0};
              end else if (o == 4'd1) begin
                topic_len_next = topic_len_next | {8'd0, b};
                if (topic_len_next == 16'd0) begin
                  if (topic_cnt_next != 8'hFF) topic_cnt_next = topic_cnt_next + 8'd1;
                end else begin
                  phase_next = PH_TOPIC;
                end
              end
            end
            if (!stop) begin
              if (hdr_off_next != OFS_MAX) hdr_off_next = hdr_off_next + 4'd1;
              bytes_left_next = bytes_left_next - 28'd1;
              if (bytes_left_next == 28'd0) do_end = 1'b1;
            end
          end

          default: ;
        endcase
      end

      // Close the packet: late checks and the flush flag
      if (do_end) begin
        if (pkt_type_next == T_CONNECT && hdr_off_next < 4'd7) failed_next = 1'b1;
        if (pkt_type_next == T_PUBLISH &&
            (hdr_off_next < 4'd2 || phase_next == PH_TOPIC)) failed_next = 1'b1;
        if (pkt_type_next == T_DISCONNECT && !failed_next) flush_seen_next = 1'b1;
        phase_next = PH_HEADER;
      end

      // Build the result, then clear the parse state for the next payload
      if (s_axis_tlast) begin
        result[VALID_LSB]         = !failed_next && phase_next == PH_HEADER;
        result[TMASK_LSB +: 16]   = type_mask_next;
        result[VERSION_LSB +: 8]  = version_next;
        result[CFLAGS_LSB +: 8]   = conn_flags_next;
        result[KALIVE_LSB +: 16]  = ka_seconds_next;
        result[SESSION_LSB]       = session_next;
        result[RCODE_LSB +: 8]    = ret_code_next;
        result[PFLAGS_LSB +: 4]   = pub_flags_next;
        result[TCOUNT_LSB +: 8]   = topic_cnt_next;
        result[FLUSH_LSB]         = flush_seen_next;
        result[PAD_LSB]           = 1'b0;
        phase_next      = PH_HEADER;
        pkt_type_next   = '0;
        length_acc_next = '0;
        len_idx_next    = '0;
        bytes_left_next = '0;
        hdr_off_next    = '0;
        topic_len_next  = '0;
        failed_next     = 1'b0;
        flush_seen_next = 1'b0;
      end
    end
  end

  // Parse state and flow record registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pkt_type   <= '0;
      length_acc <= '0;
      len_idx    <= '0;
      bytes_left <= '0;
      hdr_off    <= '0;
      topic_len  <= '0;
      failed     <= 1'b0;
      flush_seen <= 1'b0;
      type_mask  <= '0;
      version    <= '0;
      conn_flags <= '0;
      ka_seconds <= '0;
      session    <= 1'b0;
      ret_code   <= '0;
      pub_flags  <= '0;
      topic_cnt  <= '0;
    end else begin
      phase      <= phase_next;
      pkt_type   <= pkt_type_next;
      length_acc <= length_acc_next;
      len_idx    <= len_idx_next;
      bytes_left <= bytes_left_next;
      hdr_off    <= hdr_off_next;
      topic_len  <= topic_len_next;
      failed     <= failed_next;
      flush_seen <= flush_seen_next;
      type_mask  <= type_mask_next;
      version    <= version_next;
      conn_flags <= conn_flags_next;
      ka_seconds <= ka_seconds_next;
      session    <= session_next;
      ret_code   <= ret_code_next;
      pub_flags  <= pub_flags_next;
      topic_cnt  <= topic_cnt_next;
    end
  end

  // Result register: load on a payload end, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tlast) begin
      m_axis_tdata <= result;
    end
  end

endmodule

// File: hw/rtl/mqttpp_checker.sv
// Port-level assertions for the MQTT payload parser, bound to its top level.
module mqttpp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mqttpp_pkg::OUT_W-1:0] m_axis_tdata
);
  import mqttpp_pkg::*;

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Accept input whenever the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // Issue a result after every accepted payload end
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after payload end");

  // Raise a result only for an accepted payload end
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without payload end");

  // Report exactly one packet type for a one-byte payload that opens a flow
  a_fresh_one_type: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tuser |=>
      $onehot(m_axis_tdata[TMASK_LSB +: 16]))
    else $error("type mask after new flow is not one-hot");

endmodule

bind mqtt_payload_parser_top mqttpp_checker u_mqttpp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
